/* src/tcma_pkg.sv */
// Shared types and constants for the throttle clamp moving average block.
`timescale 1ns / 1ps
package tcma_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [SAMPLE_W-1:0] SAMPLE_CLAMP = 12'd4000;
  localparam logic [LEVEL_W-1:0]  LEVEL_TOP    = 7'd100;

  // Division by 40 is a shift by three followed by a multiply by 205/1024,
  // which is exact for every quotient below 204.
  localparam int unsigned STEP_SHIFT = 3;
  localparam int unsigned SCALED_W   = SAMPLE_W - STEP_SHIFT;
  localparam logic [7:0]  FIFTH_MUL  = 8'd205;
  localparam int unsigned FIFTH_SHR  = 10;
  localparam int unsigned FIFTH_PW   = SCALED_W + 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LEVEL_MAX = 4'd0,
    CFG_LEVEL_MIN = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_max;
    logic [LEVEL_W-1:0] level_min;
  } tcma_cfg_t;

endpackage

/* src/tcma_level.sv */
// Turns one sample beat into a normalized, capped and dead-zoned level.
`timescale 1ns / 1ps
module tcma_level (
  input  logic                          enable_i,
  input  logic [tcma_pkg::SAMPLE_W-1:0] sample_i,
  input  tcma_pkg::tcma_cfg_t           cfg_i,
  output logic [tcma_pkg::LEVEL_W-1:0]  level_o
);
  import tcma_pkg::*;

  logic [SAMPLE_W-1:0] clamped;
  logic [SCALED_W-1:0] scaled;
  logic [FIFTH_PW-1:0] prod;
  logic [LEVEL_W-1:0]  raw;
  logic [LEVEL_W-1:0]  capped;

  always_comb begin
    clamped = (sample_i > SAMPLE_CLAMP) ? SAMPLE_CLAMP : sample_i;
    scaled  = clamped[SAMPLE_W-1:STEP_SHIFT];
    prod    = FIFTH_PW'(scaled) * FIFTH_PW'(FIFTH_MUL);
    raw     = prod[FIFTH_SHR +: LEVEL_W];
    capped  = (raw > cfg_i.level_max) ? cfg_i.level_max : raw;
    if (!enable_i || (capped < cfg_i.level_min)) begin
      level_o = '0;
    end else begin
      level_o = capped;
    end
  end

endmodule

/* src/tcma_cell.sv */
// One window cell: holds a level and passes it to its neighbor on each beat.
`timescale 1ns / 1ps
module tcma_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic [tcma_pkg::LEVEL_W-1:0] level_i,
  output logic [tcma_pkg::LEVEL_W-1:0] level_o
);
  import tcma_pkg::*;

  logic [LEVEL_W-1:0] level_q;
  logic [LEVEL_W-1:0] level_d;

  assign level_d = shift_i ? level_i : level_q;
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

endmodule

/* src/throttle_clamp_moving_average.sv */
// Top level of the throttle clamp moving average filter.
//
// Usage: each input beat on s_axis carries an enable flag (tdata bit 0) and a
// 12-bit throttle sample (tdata bits 12:1). The sample is clamped to 4000,
// divided by 40 into a level of 0 to 100, capped at level_max and zeroed
// below level_min; a low enable gives level zero. Each level enters a row of
// WINDOW cells that shift once per accepted beat, and a running sum adds the
// new level and drops the one leaving the far end of the row. Every input
// beat yields one output beat on m_axis with the truncated window mean.
// An accepted input beat passes the sum update, reciprocal multiply and
// quotient register before its output beat. Throughput is one beat per cycle
// while m_axis_tready stays high, as the cell row shifts and the sum updates.
// The three stages each hold one beat, so input is taken while a result waits;
// when m_axis stalls long enough, the stages fill and s_axis_tready drops.
// Reset clears all cells and the sum to zero, sets level_max to 100 and
// level_min to 0, and empties the stages. The config port writes register 0
// (level_max) or 1 (level_min) when cfg_we_i is high; other indexes are
// ignored. Write it only while no beat is in flight.
`timescale 1ns / 1ps
module throttle_clamp_moving_average #(
  parameter int unsigned WINDOW = 50
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // enable, sample, zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // average_level, zero pad
  input  logic                            cfg_we_i,
  input  logic [tcma_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [tcma_pkg::LEVEL_W-1:0]    cfg_wdata_i
);
  import tcma_pkg::*;

  localparam int unsigned SumMax = WINDOW * 100;
  localparam int unsigned SumW   = $clog2(SumMax + 1);
  localparam int unsigned RecShr = SumW + $clog2(WINDOW);
  localparam int unsigned RecMul = ((2 ** RecShr) + WINDOW - 1) / WINDOW;
  localparam int unsigned RecW   = $clog2(RecMul + 1);
  localparam int unsigned ProdW  = SumW + RecW;

  tcma_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_LEVEL_MAX: cfg_d.level_max = cfg_wdata_i;
        CFG_LEVEL_MIN: cfg_d.level_min = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Stage handshakes.
  logic out_vld_q, prod_vld_q, sum_vld_q;
  logic out_rdy, prod_rdy, in_acc;

  assign out_rdy       = !out_vld_q || m_axis_tready;
  assign prod_rdy      = !prod_vld_q || out_rdy;
  assign s_axis_tready = !sum_vld_q || prod_rdy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Level of the incoming beat.
  logic [LEVEL_W-1:0] new_level;

  tcma_level u_level (
    .enable_i (s_axis_tdata[0]),
    .sample_i (s_axis_tdata[SAMPLE_W:1]),
    .cfg_i    (cfg_q),
    .level_o  (new_level)
  );

  // Row of cells; the last cell's output is the level leaving the window.
  logic [LEVEL_W-1:0] chain [WINDOW+1];

  assign chain[0] = new_level;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    tcma_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .level_i (chain[g]),
      .level_o (chain[g+1])
    );
  end

  logic [SumW-1:0]  sum_q, sum_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [LEVEL_W-1:0] avg_q, avg_d;

  assign sum_d  = sum_q - SumW'(chain[WINDOW]) + SumW'(new_level);
  assign prod_d = ProdW'(sum_q) * ProdW'(RecMul);
  assign avg_d  = prod_q[RecShr +: LEVEL_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_max <= LEVEL_TOP;
      cfg_q.level_min <= '0;
      sum_q           <= '0;
      sum_vld_q       <= 1'b0;
      prod_vld_q      <= 1'b0;
      out_vld_q       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (in_acc) begin
        sum_q     <= sum_d;
        sum_vld_q <= 1'b1;
      end else if (prod_rdy) begin
        sum_vld_q <= 1'b0;
      end
      if (prod_rdy) begin
        prod_vld_q <= sum_vld_q;
      end
      if (out_rdy) begin
        out_vld_q <= prod_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_vld_q && prod_rdy) begin
      prod_q <= prod_d;
    end
    if (prod_vld_q && out_rdy) begin
      avg_q <= avg_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, avg_q};

  // The running sum never leaves the range of a full window of top levels.
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SumW'(SumMax))
    else $error("window sum out of range");

  // An accepted beat always occupies the sum stage in the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> sum_vld_q)
    else $error("accepted beat lost from sum stage");

  // A stalled product stage keeps its contents.
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_vld_q && !out_rdy) |=> (prod_vld_q && $stable(prod_q)))
    else $error("product stage overwritten while stalled");

  // The average never exceeds the top level.
  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (avg_q <= LEVEL_TOP))
    else $error("average above top level");

endmodule

/* sim/throttle_clamp_moving_average_test.sv */
// Self-checking testbench for the throttle clamp moving average filter.
`timescale 1ns / 1ps
module throttle_clamp_moving_average_test;
  import tcma_pkg::*;

  localparam int unsigned WINDOW      = 50;
  localparam int unsigned LATENCY     = 3;
  localparam int unsigned SAMPLE_STEP = 40;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_BEATS = 85;
  // Indexes outside the register list; each one aliases a real register
  // in some of its low bits, so a sloppy decode would show up.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_TWO   = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_THREE = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_TOP   = 4'd15;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                enable;
  } throttle_beat_t;

  typedef enum int unsigned {
    RUN_UNIFORM, RUN_FULL_SCALE, RUN_LOW_END, RUN_MOSTLY_OFF, RUN_NARROW_BAND
  } run_style_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;  // enable, sample[11:0], zero pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;       // average_level[6:0], zero pad
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [LEVEL_W-1:0]    cfg_wdata_i = '0;

  throttle_beat_t     pending_beats [$];
  logic [LEVEL_W-1:0] expected_avgs [$];

  // Predictor state.
  logic [LEVEL_W-1:0] level_cap = LEVEL_TOP;
  logic [LEVEL_W-1:0] level_floor = '0;
  logic [LEVEL_W-1:0] level_hist [WINDOW] = '{default: '0};
  int unsigned        hist_pos = 0;
  logic [12:0]        level_total = '0;

  int unsigned send_odds = 0;
  int unsigned recv_odds = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned fail_count = 0;
  int unsigned beats_in = 0;
  int unsigned avgs_checked = 0;
  int unsigned settings_run = 1;
  int unsigned peak_avg = 0;

  logic [LEVEL_W-1:0] cap_list   [NUM_PHASES] = '{7'd127, 7'd75, 7'd0, 7'd100,
                                                  7'd127, 7'd10, 7'd0, 7'd100};
  logic [LEVEL_W-1:0] floor_list [NUM_PHASES] = '{7'd0, 7'd20, 7'd0, 7'd100,
                                                  7'd127, 7'd50, 7'd0, 7'd0};

  throttle_clamp_moving_average #(.WINDOW(WINDOW)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [LEVEL_W-1:0] throttle_level(logic en, logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] clipped;
    logic [LEVEL_W-1:0]  lvl;
    if (!en) return '0;
    clipped = (raw > SAMPLE_CLAMP) ? SAMPLE_CLAMP : raw;
    lvl = LEVEL_W'(clipped / SAMPLE_STEP);
    if (lvl > level_cap) lvl = level_cap;
    if (lvl < level_floor) lvl = '0;
    return lvl;
  endfunction

  // Slide the window by one level and queue the mean it yields.
  task automatic predict_average(throttle_beat_t beat);
    logic [LEVEL_W-1:0] lvl;
    lvl = throttle_level(beat.enable, beat.sample);
    level_total = level_total - 13'(level_hist[hist_pos]) + 13'(lvl);
    level_hist[hist_pos] = lvl;
    hist_pos = (hist_pos + 1 == WINDOW) ? 0 : hist_pos + 1;
    expected_avgs.push_back(LEVEL_W'(level_total / WINDOW));
  endtask

  // Input side: one beat per handshake, with random idle bursts.
  always @(posedge clk_i) begin
    throttle_beat_t beat;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_average(throttle_beat_t'(s_axis_tdata[12:0]));
        beats_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap == 0 && send_odds != 0 && pending_beats.size() != 0 &&
            $urandom_range(0, send_odds - 1) == 0)
          send_gap = $urandom_range(1, 5);
        if (send_gap != 0 || pending_beats.size() == 0) begin
          if (send_gap != 0) send_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          beat = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, beat};
        end
      end
    end
  end

  // Output side: check each result beat and stall at random.
  always @(posedge clk_i) begin
    logic [LEVEL_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_avgs.size() == 0) begin
        $display("%t: unexpected result beat, actual average %0d",
                 $realtime, m_axis_tdata[6:0]);
        fail_count++;
      end else begin
        want = expected_avgs.pop_front();
        avgs_checked++;
        if (m_axis_tdata[6:0] > peak_avg) peak_avg = 32'(m_axis_tdata[6:0]);
        if (m_axis_tdata[6:0] !== want || m_axis_tdata[7] !== 1'b0) begin
          $display("%t: average mismatch, expected %0d (pad 0), actual %0d (pad %b)",
                   $realtime, want, m_axis_tdata[6:0], m_axis_tdata[7]);
          fail_count++;
        end
      end
    end
    if (recv_gap == 0 && recv_odds != 0 && $urandom_range(0, recv_odds - 1) == 0)
      recv_gap = $urandom_range(1, 5);
    if (recv_gap != 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [LEVEL_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    if (idx == CFG_LEVEL_MAX) level_cap = value;
    else if (idx == CFG_LEVEL_MIN) level_floor = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_avgs.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic queue_beat(logic en, logic [SAMPLE_W-1:0] raw);
    throttle_beat_t beat;
    beat.enable = en;
    beat.sample = raw;
    pending_beats.push_back(beat);
  endtask

  // Runs of related samples, so the window fills with one kind of level
  // and the average actually climbs to the cap or settles near the floor.
  task automatic queue_random(int unsigned count);
    int unsigned left;
    int unsigned run;
    int unsigned band;
    run_style_e  style;
    logic        en;
    logic [SAMPLE_W-1:0] raw;
    left = count;
    while (left > 0) begin
      run = $urandom_range(5, 60);
      if (run > left) run = left;
      style = run_style_e'($urandom_range(0, 4));
      band = $urandom_range(0, 3975);
      repeat (run) begin
        en = ($urandom_range(0, 9) != 0);
        case (style)
          RUN_UNIFORM:    raw = SAMPLE_W'($urandom_range(0, 4095));
          RUN_FULL_SCALE: raw = SAMPLE_W'($urandom_range(3900, 4095));
          RUN_LOW_END:    raw = SAMPLE_W'($urandom_range(0, 240));
          RUN_MOSTLY_OFF: begin
            en  = ($urandom_range(0, 3) == 0);
            raw = SAMPLE_W'($urandom_range(0, 4095));
          end
          default:        raw = SAMPLE_W'($urandom_range(band, band + 120));
        endcase
        queue_beat(en, raw);
      end
      left -= run;
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    send_odds = 6;
    recv_odds = 6;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Field extremes and clamp edges under the reset register values.
    queue_beat(1'b1, 12'd0);
    queue_beat(1'b1, 12'd4095);
    queue_beat(1'b1, 12'd4000);
    queue_beat(1'b1, 12'd4001);
    queue_beat(1'b1, 12'd3999);
    queue_beat(1'b1, 12'd39);
    queue_beat(1'b1, 12'd40);
    queue_beat(1'b1, 12'hAAA);
    queue_beat(1'b1, 12'h555);
    queue_beat(1'b0, 12'd4095);
    queue_beat(1'b0, 12'd0);
    queue_beat(1'b1, 12'd2048);
    wait_idle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 2) begin
        write_reg(CFG_LEVEL_MAX, LEVEL_W'($urandom_range(0, 127)));
        write_reg(CFG_LEVEL_MIN, LEVEL_W'($urandom_range(0, 60)));
      end else begin
        write_reg(CFG_LEVEL_MAX, cap_list[ph]);
        write_reg(CFG_LEVEL_MIN, floor_list[ph]);
      end
      // Writes to unlisted indexes must leave both registers alone.
      if (ph == 0) begin
        write_reg(CFG_SPARE_TWO, 7'd0);
        write_reg(CFG_SPARE_THREE, 7'd127);
        write_reg(CFG_SPARE_TOP, 7'd0);
      end
      settings_run++;
      @(negedge clk_i);
      // Most phases have random idle bursts; phase 3 sends and phase 4 receives
      // without idling, and the last one runs with no idling at all.
      send_odds = (ph == NUM_PHASES - 1 || ph == 3) ? 0 : $urandom_range(2, 8);
      recv_odds = (ph == NUM_PHASES - 1 || ph == 4) ? 0 : $urandom_range(2, 8);
      queue_random(PHASE_BEATS);
      wait_idle();
    end

    repeat (4 * LATENCY) @(posedge clk_i);
    if (expected_avgs.size() != 0) begin
      $display("%t: %0d expected averages never arrived", $realtime, expected_avgs.size());
      fail_count++;
    end
    $display("Streamed %0d throttle beats and checked %0d averages", beats_in, avgs_checked);
    $display("across %0d register settings; highest average seen %0d", settings_run, peak_avg);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("%t: run did not finish in time", $realtime);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/tcma_pkg.sv
src/tcma_level.sv
src/tcma_cell.sv
src/throttle_clamp_moving_average.sv
sim/throttle_clamp_moving_average_test.sv
